>>> src/asip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asip_pkg
// Shared types, codes and helpers of the auto-step index pointer table.
// ----------------------------------------------------------------------------
package asip_pkg;

    localparam int ENTRY_COUNT_DEF  = 256;
    localparam int MEMORY_BYTES_DEF = 262144;
    localparam int ADDR_W           = 24;

    // actions
    localparam logic [2:0] ACT_READ      = 3'd0;
    localparam logic [2:0] ACT_WRITE     = 3'd1;
    localparam logic [2:0] ACT_GET_CFG   = 3'd2;
    localparam logic [2:0] ACT_SET_CFG   = 3'd3;
    localparam logic [2:0] ACT_WINDOW    = 3'd4;
    localparam logic [2:0] ACT_RESET_ALL = 3'd5;

    // configuration field codes
    localparam logic [3:0] FLD_CUR_L   = 4'd0;
    localparam logic [3:0] FLD_CUR_M   = 4'd1;
    localparam logic [3:0] FLD_CUR_H   = 4'd2;
    localparam logic [3:0] FLD_DEF_L   = 4'd3;
    localparam logic [3:0] FLD_DEF_M   = 4'd4;
    localparam logic [3:0] FLD_DEF_H   = 4'd5;
    localparam logic [3:0] FLD_LIM_L   = 4'd6;
    localparam logic [3:0] FLD_LIM_M   = 4'd7;
    localparam logic [3:0] FLD_LIM_H   = 4'd8;
    localparam logic [3:0] FLD_STEP    = 4'd9;
    localparam logic [3:0] FLD_FLAGS   = 4'd10;
    localparam logic [3:0] FLD_CPY_SRC = 4'd11;
    localparam logic [3:0] FLD_CPY_DST = 4'd12;
    localparam logic [3:0] FLD_CPY_LNL = 4'd13;
    localparam logic [3:0] FLD_CPY_LNH = 4'd14;

    // window commands
    localparam logic [7:0] WIN_NOP       = 8'd0;
    localparam logic [7:0] WIN_CUR_DEF   = 8'd1;
    localparam logic [7:0] WIN_DEF_CUR   = 8'd2;
    localparam logic [7:0] WIN_LIM_CUR   = 8'd3;

    // mode flag bits
    localparam int MODE_AUTO = 0;
    localparam int MODE_BACK = 1;
    localparam int MODE_WRAP = 2;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] index;
        logic [3:0] field_code;
        logic [7:0] data;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       address_error;
    } t_rsp;

    typedef struct packed {
        t_addr      cur;
        t_addr      dflt;
        t_addr      lim;
        logic [7:0] step;
        logic [7:0] flags;
    } t_entry;

    typedef struct packed {
        logic re;
        logic we;
    } t_mem_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_RESP,
        ST_SWP_RD,
        ST_SWP_WR
    } t_state;

    // byte lane of an address field code
    function automatic logic [1:0] fld_lane(input logic [3:0] code);
        logic [1:0] lane;
        case (code)
            FLD_CUR_L, FLD_DEF_L, FLD_LIM_L: lane = 2'd0;
            FLD_CUR_M, FLD_DEF_M, FLD_LIM_M: lane = 2'd1;
            default:                         lane = 2'd2;
        endcase
        return lane;
    endfunction

    function automatic logic [7:0] get_lane(input t_addr w, input logic [1:0] lane);
        logic [7:0] v;
        case (lane)
            2'd0:    v = w[7:0];
            2'd1:    v = w[15:8];
            default: v = w[23:16];
        endcase
        return v;
    endfunction

    function automatic t_addr put_lane(input t_addr w, input logic [1:0] lane,
                                       input logic [7:0] v);
        t_addr r;
        r = w;
        case (lane)
            2'd0:    r[7:0]   = v;
            2'd1:    r[15:8]  = v;
            default: r[23:16] = v;
        endcase
        return r;
    endfunction

endpackage

>>> src/asip_tab.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asip_tab
// Pointer table memory: one port, registered read, per-entry valid bits so
// that entries never written read as all zero after reset.
// ----------------------------------------------------------------------------
module asip_tab
    import asip_pkg::*;
#(
    parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
    localparam int TAB_AW     = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_ctl          i_ctl,
    input  logic [TAB_AW-1:0] i_addr,
    input  t_entry            i_wdata,
    output t_entry            o_rdata
);

    t_entry r_mem [ENTRY_COUNT];
    logic   r_vld [ENTRY_COUNT];
    t_entry r_q;
    logic   r_q_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_q    <= r_mem[i_addr];
            r_q_ok <= r_vld[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (i_ctl.we) begin
            r_vld[i_addr] <= 1'b1;
        end
    end

    assign o_rdata = r_q_ok ? r_q : '0;

endmodule

>>> src/asip_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asip_mem
// Byte memory: single port, registered read. Contents undefined until written.
// ----------------------------------------------------------------------------
module asip_mem
    import asip_pkg::*;
#(
    parameter int MEMORY_BYTES = MEMORY_BYTES_DEF,
    localparam int MEM_AW      = $clog2(MEMORY_BYTES)
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [MEM_AW-1:0] i_addr,
    input  logic [7:0]        i_wdata,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [MEMORY_BYTES];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

>>> src/asip_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asip_ctrl
// Request sequencer: reads the addressed entry, modifies it, writes it back,
// drives the byte memory and holds the response register.
// ----------------------------------------------------------------------------
module asip_ctrl
    import asip_pkg::*;
#(
    parameter int ENTRY_COUNT  = ENTRY_COUNT_DEF,
    parameter int MEMORY_BYTES = MEMORY_BYTES_DEF,
    localparam int TAB_AW      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1,
    localparam int MEM_AW      = $clog2(MEMORY_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  t_req              i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_stall,
    output t_rsp              o_rsp,
    output t_mem_ctl          o_tab_ctl,
    output logic [TAB_AW-1:0] o_tab_addr,
    output t_entry            o_tab_wdata,
    input  t_entry            i_tab_rdata,
    output t_mem_ctl          o_mem_ctl,
    output logic [MEM_AW-1:0] o_mem_addr,
    output logic [7:0]        o_mem_wdata,
    input  logic [7:0]        i_mem_rdata
);

    localparam logic [24:0]       MEM_LIMIT = 25'(MEMORY_BYTES);
    localparam logic [8:0]        TAB_LIMIT = 9'(ENTRY_COUNT);
    localparam logic [TAB_AW-1:0] TAB_LAST  = TAB_AW'(ENTRY_COUNT - 1);

    t_state            r_state, n_state;
    t_req              r_req;
    logic [7:0]        r_res_data;
    logic              r_res_err;
    logic              r_res_mem;
    logic [TAB_AW-1:0] r_cnt;
    logic [7:0]        r_cpy_src;
    logic [7:0]        r_cpy_dst;
    logic [15:0]       r_cpy_len;
    logic              r_rsp_valid;
    t_rsp              r_rsp;

    logic       rsp_free;
    logic       accept;
    logic       push;
    logic       in_ok;
    // work done in the lookup cycle
    logic       ok;
    logic       oob;
    t_entry     ent;
    t_entry     upd;
    logic       upd_we;
    logic       acc_re;
    logic       acc_we;
    logic [7:0] res_data;
    logic       res_err;
    t_addr      a_step;
    logic [1:0] lane;

    assign rsp_free = !r_rsp_valid || !i_rsp_stall;
    assign accept   = i_req_valid && !o_req_stall;
    assign in_ok    = {1'b0, i_req.index} < TAB_LIMIT;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                if (r_req.action == ACT_RESET_ALL) n_state = ST_SWP_RD;
                else                               n_state = ST_RESP;
            end
            ST_RESP: begin
                if (rsp_free) n_state = accept ? ST_LOOK : ST_IDLE;
            end
            ST_SWP_RD: n_state = ST_SWP_WR;
            ST_SWP_WR: begin
                n_state = (r_cnt == TAB_LAST) ? ST_RESP : ST_SWP_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // entry update for the request under work
    always_comb begin
        ent      = i_tab_rdata;
        upd      = ent;
        upd_we   = 1'b0;
        acc_re   = 1'b0;
        acc_we   = 1'b0;
        res_data = '0;
        res_err  = 1'b0;
        ok       = {1'b0, r_req.index} < TAB_LIMIT;
        oob      = {1'b0, ent.cur} >= MEM_LIMIT;
        lane     = fld_lane(r_req.field_code);
        if (ent.flags[MODE_BACK]) begin
            a_step = ent.cur - {16'b0, ent.step};
            if (ent.flags[MODE_WRAP] && a_step < ent.lim) a_step = ent.dflt;
        end else begin
            a_step = ent.cur + {16'b0, ent.step};
            if (ent.flags[MODE_WRAP] && a_step >= ent.lim) a_step = ent.dflt;
        end
        case (r_req.action)
            ACT_READ, ACT_WRITE: begin
                if (ok) begin
                    if (oob) begin
                        res_err = 1'b1;
                    end else begin
                        acc_re = (r_req.action == ACT_READ);
                        acc_we = (r_req.action == ACT_WRITE);
                        if (ent.flags[MODE_AUTO]) begin
                            upd.cur = a_step;
                            upd_we  = 1'b1;
                        end
                    end
                end
            end
            ACT_GET_CFG: begin
                case (r_req.field_code)
                    FLD_CPY_SRC: res_data = r_cpy_src;
                    FLD_CPY_DST: res_data = r_cpy_dst;
                    FLD_CPY_LNL: res_data = r_cpy_len[7:0];
                    FLD_CPY_LNH: res_data = r_cpy_len[15:8];
                    FLD_CUR_L, FLD_CUR_M, FLD_CUR_H: begin
                        if (ok) res_data = get_lane(ent.cur, lane);
                    end
                    FLD_DEF_L, FLD_DEF_M, FLD_DEF_H: begin
                        if (ok) res_data = get_lane(ent.dflt, lane);
                    end
                    FLD_LIM_L, FLD_LIM_M, FLD_LIM_H: begin
                        if (ok) res_data = get_lane(ent.lim, lane);
                    end
                    FLD_STEP: begin
                        if (ok) res_data = ent.step;
                    end
                    FLD_FLAGS: begin
                        if (ok) res_data = ent.flags;
                    end
                    default: res_data = '0;
                endcase
            end
            ACT_SET_CFG: begin
                upd_we = ok;
                case (r_req.field_code)
                    FLD_CUR_L, FLD_CUR_M, FLD_CUR_H:
                        upd.cur = put_lane(ent.cur, lane, r_req.data);
                    FLD_DEF_L, FLD_DEF_M, FLD_DEF_H:
                        upd.dflt = put_lane(ent.dflt, lane, r_req.data);
                    FLD_LIM_L, FLD_LIM_M, FLD_LIM_H:
                        upd.lim = put_lane(ent.lim, lane, r_req.data);
                    FLD_STEP:  upd.step  = r_req.data;
                    FLD_FLAGS: upd.flags = r_req.data;
                    default:   upd_we    = 1'b0;
                endcase
            end
            ACT_WINDOW: begin
                upd_we = ok;
                case (r_req.data)
                    WIN_CUR_DEF: upd.cur  = ent.dflt;
                    WIN_DEF_CUR: upd.dflt = ent.cur;
                    WIN_LIM_CUR: upd.lim  = ent.cur;
                    default:     upd_we   = 1'b0;
                endcase
            end
            default: upd_we = 1'b0;
        endcase
    end

    // outputs per state
    always_comb begin
        o_req_stall = 1'b1;
        push        = 1'b0;
        o_tab_ctl   = '0;
        o_tab_addr  = r_req.index[TAB_AW-1:0];
        o_tab_wdata = upd;
        o_mem_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                o_req_stall  = 1'b0;
                o_tab_ctl.re = i_req_valid && in_ok;
                o_tab_addr   = i_req.index[TAB_AW-1:0];
            end
            ST_LOOK: begin
                o_tab_ctl.we = upd_we;
                o_mem_ctl.re = acc_re;
                o_mem_ctl.we = acc_we;
            end
            ST_RESP: begin
                o_req_stall  = !rsp_free;
                push         = rsp_free;
                o_tab_ctl.re = i_req_valid && rsp_free && in_ok;
                o_tab_addr   = i_req.index[TAB_AW-1:0];
            end
            ST_SWP_RD: begin
                o_tab_ctl.re = 1'b1;
                o_tab_addr   = r_cnt;
            end
            ST_SWP_WR: begin
                o_tab_ctl.we    = 1'b1;
                o_tab_addr      = r_cnt;
                o_tab_wdata     = ent;
                o_tab_wdata.cur = ent.dflt;
            end
            default: o_req_stall = 1'b1;
        endcase
        // nothing is taken while reset is held
        if (!i_rst_n) o_req_stall = 1'b1;
    end

    assign o_mem_addr  = ent.cur[MEM_AW-1:0];
    assign o_mem_wdata = r_req.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_cpy_src   <= '0;
            r_cpy_dst   <= '0;
            r_cpy_len   <= '0;
            r_rsp_valid <= 1'b0;
            r_res_mem   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_LOOK) begin
                r_cnt     <= '0;
                r_res_mem <= acc_re;
                if (r_req.action == ACT_SET_CFG) begin
                    case (r_req.field_code)
                        FLD_CPY_SRC: r_cpy_src       <= r_req.data;
                        FLD_CPY_DST: r_cpy_dst       <= r_req.data;
                        FLD_CPY_LNL: r_cpy_len[7:0]  <= r_req.data;
                        FLD_CPY_LNH: r_cpy_len[15:8] <= r_req.data;
                        default: ;
                    endcase
                end
            end
            if (r_state == ST_SWP_WR) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (rsp_free) begin
                r_rsp_valid <= push;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (r_state == ST_LOOK) begin
            r_res_data <= res_data;
            r_res_err  <= res_err;
        end
        if (push) begin
            r_rsp.read_data     <= r_res_mem ? i_mem_rdata : r_res_data;
            r_rsp.address_error <= r_res_err;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

>>> src/auto_step_index_pointer_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_step_index_pointer_table_top
// Pointer table with auto-stepping addresses in front of a byte memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_req_valid / o_req_stall / i_req) carries one action:
//   memory read or write through an entry, config byte get or set, window
//   command, or reset of all entries to their default address.
//   Response channel (o_rsp_valid / i_rsp_stall / o_rsp) returns exactly one
//   response per request, in order.
//   A taken request passes the entry lookup, then the response register.
//   Reset-all walks the table entry by entry, reading each entry and writing
//   it back with its current address set to its default address.
//   Requests do not overlap, as the table has a single read-modify-write
//   port; the next request is taken in the same cycle the response register
//   loads.
//   While the receiver stalls, the response holds and at most one more
//   request is taken and parked before the request side stalls.
//   After reset all entries read as zero; memory bytes are undefined until
//   written.
// ----------------------------------------------------------------------------
module auto_step_index_pointer_table_top
    import asip_pkg::*;
#(
    parameter int ENTRY_COUNT  = ENTRY_COUNT_DEF,
    parameter int MEMORY_BYTES = MEMORY_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    localparam int TAB_AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int MEM_AW = $clog2(MEMORY_BYTES);

    t_mem_ctl          tab_ctl;
    logic [TAB_AW-1:0] tab_addr;
    t_entry            tab_wdata;
    t_entry            tab_rdata;
    t_mem_ctl          mem_ctl;
    logic [MEM_AW-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;

    asip_ctrl #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .MEMORY_BYTES(MEMORY_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_stall(o_req_stall),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_stall(i_rsp_stall),
        .o_rsp      (o_rsp),
        .o_tab_ctl  (tab_ctl),
        .o_tab_addr (tab_addr),
        .o_tab_wdata(tab_wdata),
        .i_tab_rdata(tab_rdata),
        .o_mem_ctl  (mem_ctl),
        .o_mem_addr (mem_addr),
        .o_mem_wdata(mem_wdata),
        .i_mem_rdata(mem_rdata)
    );

    asip_tab #(
        .ENTRY_COUNT(ENTRY_COUNT)
    ) u_tab (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (tab_ctl),
        .i_addr (tab_addr),
        .i_wdata(tab_wdata),
        .o_rdata(tab_rdata)
    );

    asip_mem #(
        .MEMORY_BYTES(MEMORY_BYTES)
    ) u_mem (
        .i_clk  (i_clk),
        .i_ctl  (mem_ctl),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

endmodule

>>> verif/auto_step_index_pointer_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_step_index_pointer_table_top_tb
// Self-checking bench for the auto-step pointer table. A scoreboard keeps its
// own copy of the table and the byte memory, predicts one response per
// accepted request and checks the responses in order. Stimulus is a short
// directed run, then random entry setups with write/read bursts mixed with
// noise, under several idle, stall and backpressure phases.
// ----------------------------------------------------------------------------
module auto_step_index_pointer_table_top_tb;
    import asip_pkg::*;

    localparam int ENTRIES   = ENTRY_COUNT_DEF;
    localparam int MEM_BYTES = MEMORY_BYTES_DEF;
    localparam int TAIL      = 2 * ENTRIES + 8;

    localparam logic [2:0] ACT_UNUSED_6 = 3'd6;

    class pointer_scoreboard;
        t_addr      cur_addr [ENTRIES] = '{default: '0};
        t_addr      dflt_addr[ENTRIES] = '{default: '0};
        t_addr      lim_addr [ENTRIES] = '{default: '0};
        logic [7:0] step_size[ENTRIES] = '{default: '0};
        logic [7:0] mode     [ENTRIES] = '{default: '0};
        logic [7:0] mem_bytes[int];
        logic [7:0] copy_src = '0;
        logic [7:0] copy_dst = '0;
        logic [15:0] copy_len = '0;
        t_rsp       rsp_due[$];
        int         errors = 0;

        function bit byte_known(int e);
            return cur_addr[e] >= MEM_BYTES || mem_bytes.exists(int'(cur_addr[e]));
        endfunction

        function void step_pointer(int e);
            t_addr a;
            a = cur_addr[e];
            if (!mode[e][MODE_AUTO]) return;
            if (mode[e][MODE_BACK]) begin
                a = a - t_addr'(step_size[e]);
                if (mode[e][MODE_WRAP] && a < lim_addr[e]) a = dflt_addr[e];
            end else begin
                a = a + t_addr'(step_size[e]);
                if (mode[e][MODE_WRAP] && a >= lim_addr[e]) a = dflt_addr[e];
            end
            cur_addr[e] = a;
        endfunction

        function logic [7:0] read_field(int e, logic [3:0] code);
            int lane;
            lane = code % 3;
            if (code <= FLD_CUR_H) return cur_addr[e][8*lane +: 8];
            if (code <= FLD_DEF_H) return dflt_addr[e][8*lane +: 8];
            if (code <= FLD_LIM_H) return lim_addr[e][8*lane +: 8];
            case (code)
                FLD_STEP:    return step_size[e];
                FLD_FLAGS:   return mode[e];
                FLD_CPY_SRC: return copy_src;
                FLD_CPY_DST: return copy_dst;
                FLD_CPY_LNL: return copy_len[7:0];
                FLD_CPY_LNH: return copy_len[15:8];
                default:     return 8'h00;
            endcase
        endfunction

        function void write_field(int e, logic [3:0] code, logic [7:0] v);
            int lane;
            lane = code % 3;
            if (code <= FLD_CUR_H) cur_addr[e][8*lane +: 8] = v;
            else if (code <= FLD_DEF_H) dflt_addr[e][8*lane +: 8] = v;
            else if (code <= FLD_LIM_H) lim_addr[e][8*lane +: 8] = v;
            else begin
                case (code)
                    FLD_STEP:    step_size[e] = v;
                    FLD_FLAGS:   mode[e] = v;
                    FLD_CPY_SRC: copy_src = v;
                    FLD_CPY_DST: copy_dst = v;
                    FLD_CPY_LNL: copy_len[7:0] = v;
                    FLD_CPY_LNH: copy_len[15:8] = v;
                    default: ;
                endcase
            end
        endfunction

        function t_rsp predict_response(t_req r);
            t_rsp o;
            int   e;
            o = '0;
            e = r.index;
            case (r.action)
                ACT_READ, ACT_WRITE: begin
                    if (cur_addr[e] >= MEM_BYTES) begin
                        o.address_error = 1'b1;
                    end else begin
                        if (r.action == ACT_READ)
                            o.read_data = mem_bytes[int'(cur_addr[e])];
                        else
                            mem_bytes[int'(cur_addr[e])] = r.data;
                        step_pointer(e);
                    end
                end
                ACT_GET_CFG: o.read_data = read_field(e, r.field_code);
                ACT_SET_CFG: write_field(e, r.field_code, r.data);
                ACT_WINDOW: begin
                    case (r.data)
                        WIN_CUR_DEF: cur_addr[e] = dflt_addr[e];
                        WIN_DEF_CUR: dflt_addr[e] = cur_addr[e];
                        WIN_LIM_CUR: lim_addr[e] = cur_addr[e];
                        default: ;
                    endcase
                end
                ACT_RESET_ALL: foreach (cur_addr[i]) cur_addr[i] = dflt_addr[i];
                default: ;
            endcase
            return o;
        endfunction

        function void note_request(t_req r);
            rsp_due.push_back(predict_response(r));
        endfunction

        function void check_response(t_rsp r);
            t_rsp want;
            if (rsp_due.size() == 0) begin
                errors++;
                $display("%0t: response with no request outstanding: expected none, actual %h",
                         $time, r);
                return;
            end
            want = rsp_due.pop_front();
            if (r.read_data !== want.read_data) begin
                errors++;
                $display("%0t: read_data mismatch: expected %h, actual %h",
                         $time, want.read_data, r.read_data);
            end
            if (r.address_error !== want.address_error) begin
                errors++;
                $display("%0t: address_error mismatch: expected %b, actual %b",
                         $time, want.address_error, r.address_error);
            end
        endfunction

        function int pending();
            return rsp_due.size();
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_stall;
    t_req i_req       = '0;
    logic o_rsp_valid;
    logic i_rsp_stall = 1'b0;
    t_rsp o_rsp;

    pointer_scoreboard sb = new();
    t_req plan[$];
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   hold_cycles   = 0;

    auto_step_index_pointer_table_top #(
        .ENTRY_COUNT (ENTRIES),
        .MEMORY_BYTES(MEM_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_stall(o_req_stall),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_stall(i_rsp_stall),
        .o_rsp      (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // response side: check, then pick next stall; long hold-offs counted here
    always @(posedge i_clk) begin
        if (o_rsp_valid && !i_rsp_stall) sb.check_response(o_rsp);
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_rsp_stall <= 1'b1;
        end else begin
            i_rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic t_req make_req(logic [2:0] act, logic [7:0] idx,
                                      logic [3:0] fld, logic [7:0] d);
        t_req r;
        r.action     = act;
        r.index      = idx;
        r.field_code = fld;
        r.data       = d;
        return r;
    endfunction

    function automatic t_addr pick_addr();
        case ($urandom_range(9))
            0:       return t_addr'(MEM_BYTES - 24 + $urandom_range(47));
            1:       return t_addr'($urandom_range(24'hFFFFFF));
            2:       return t_addr'(24'hFFFFFF - $urandom_range(40));
            default: return t_addr'($urandom_range(MEM_BYTES - 1));
        endcase
    endfunction

    // Either an entry setup followed by a write burst, a jump to the default
    // address and a read burst of the same length, or one noise request.
    function automatic void build_plan();
        logic [7:0] idx, flg, stp;
        t_addr      base, dflt_a, lim_a, span;
        int         runs, b;
        t_req       junk;
        if ($urandom_range(99) < 70) begin
            idx    = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
            base   = pick_addr();
            flg    = 8'($urandom);
            flg[MODE_AUTO] = ($urandom_range(9) != 0);
            stp    = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 8));
            span   = t_addr'($urandom_range(1, 96));
            dflt_a = ($urandom_range(3) == 0) ? pick_addr() : base;
            lim_a  = flg[MODE_BACK] ? base - span : base + span;
            if ($urandom_range(4) == 0) lim_a = pick_addr();
            for (b = 0; b < 3; b++) begin
                plan.push_back(make_req(ACT_SET_CFG, idx, 4'(FLD_CUR_L + b), base[8*b +: 8]));
                plan.push_back(make_req(ACT_SET_CFG, idx, 4'(FLD_DEF_L + b), dflt_a[8*b +: 8]));
                plan.push_back(make_req(ACT_SET_CFG, idx, 4'(FLD_LIM_L + b), lim_a[8*b +: 8]));
            end
            plan.push_back(make_req(ACT_SET_CFG, idx, FLD_STEP, stp));
            plan.push_back(make_req(ACT_SET_CFG, idx, FLD_FLAGS, flg));
            runs = $urandom_range(2, 12);
            for (b = 0; b < runs; b++)
                plan.push_back(make_req(ACT_WRITE, idx, 4'($urandom), 8'($urandom)));
            if ($urandom_range(1) == 0)
                plan.push_back(make_req(ACT_GET_CFG, idx, 4'($urandom), 8'($urandom)));
            plan.push_back(make_req(ACT_WINDOW, idx, 4'($urandom), WIN_CUR_DEF));
            for (b = 0; b < runs; b++)
                plan.push_back(make_req(ACT_READ, idx, 4'($urandom), 8'($urandom)));
            if ($urandom_range(3) == 0)
                plan.push_back(make_req(ACT_WINDOW, idx, 4'($urandom),
                                        ($urandom_range(1) == 0) ? WIN_DEF_CUR : WIN_LIM_CUR));
        end else begin
            junk.action     = 3'($urandom_range(7));
            junk.index      = ($urandom_range(1) == 0) ? 8'($urandom_range(7)) : 8'($urandom);
            junk.field_code = 4'($urandom);
            junk.data       = 8'($urandom);
            if (junk.action == ACT_WINDOW && $urandom_range(1) == 0)
                junk.data = 8'($urandom_range(5));
            // keep the slow table walk rare
            if (junk.action == ACT_RESET_ALL && $urandom_range(3) != 0)
                junk.action = ACT_GET_CFG;
            plan.push_back(junk);
        end
    endfunction

    function automatic t_req next_request();
        t_req r;
        if (plan.size() == 0) build_plan();
        r = plan.pop_front();
        // never read a byte that holds no written value
        if (r.action == ACT_READ && !sb.byte_known(r.index)) r.action = ACT_WRITE;
        return r;
    endfunction

    task automatic send_items(input int count);
        int done;
        done = 0;
        while (done < count) begin
            @(posedge i_clk);
            if (i_req_valid && !o_req_stall) begin
                sb.note_request(i_req);
                if (i_req.action <= ACT_RESET_ALL) done++;
            end
            if (i_req_valid && o_req_stall) begin
                // stalled request holds
            end else if (done >= count || $urandom_range(99) < send_idle_pct) begin
                i_req_valid <= 1'b0;
            end else begin
                i_req       <= next_request();
                i_req_valid <= 1'b1;
            end
        end
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan.push_back(make_req(ACT_GET_CFG, 8'd0, FLD_FLAGS, 8'h00));
        plan.push_back(make_req(ACT_WRITE, 8'd0, 4'hF, 8'h00));
        plan.push_back(make_req(ACT_READ, 8'd0, 4'h0, 8'hFF));
        // last memory byte, then a big step past the end
        plan.push_back(make_req(ACT_SET_CFG, 8'd3, FLD_CUR_L, 8'hFF));
        plan.push_back(make_req(ACT_SET_CFG, 8'd3, FLD_CUR_M, 8'hFF));
        plan.push_back(make_req(ACT_SET_CFG, 8'd3, FLD_CUR_H, 8'h03));
        plan.push_back(make_req(ACT_SET_CFG, 8'd3, FLD_STEP, 8'hFF));
        plan.push_back(make_req(ACT_SET_CFG, 8'd3, FLD_FLAGS, 8'(1 << MODE_AUTO)));
        plan.push_back(make_req(ACT_WRITE, 8'd3, 4'h0, 8'hFF));
        plan.push_back(make_req(ACT_READ, 8'd3, 4'hF, 8'h00));
        plan.push_back(make_req(ACT_WINDOW, 8'd3, 4'h0, WIN_CUR_DEF));
        // backward step below zero wraps modulo the address width
        plan.push_back(make_req(ACT_SET_CFG, 8'd3, FLD_FLAGS, 8'hFF));
        plan.push_back(make_req(ACT_WRITE, 8'd3, 4'h0, 8'h5A));
        plan.push_back(make_req(ACT_GET_CFG, 8'd3, FLD_CUR_H, 8'h00));
        plan.push_back(make_req(ACT_WINDOW, 8'd3, 4'h0, WIN_LIM_CUR));
        plan.push_back(make_req(ACT_WINDOW, 8'd3, 4'h0, WIN_DEF_CUR));
        plan.push_back(make_req(ACT_WINDOW, 8'd3, 4'h0, 8'hFF));
        plan.push_back(make_req(ACT_WINDOW, 8'd3, 4'h0, WIN_NOP));
        plan.push_back(make_req(ACT_SET_CFG, 8'hFF, FLD_CPY_LNH, 8'hAA));
        plan.push_back(make_req(ACT_GET_CFG, 8'h00, FLD_CPY_LNH, 8'h00));
        plan.push_back(make_req(ACT_SET_CFG, 8'd0, 4'hF, 8'hFF));
        plan.push_back(make_req(ACT_GET_CFG, 8'd0, 4'hF, 8'h00));
        plan.push_back(make_req(ACT_UNUSED_6, 8'hFF, 4'hF, 8'hFF));
        plan.push_back(make_req(ACT_RESET_ALL, 8'd0, 4'h0, 8'h00));
        plan.push_back(make_req(ACT_GET_CFG, 8'd3, FLD_CUR_L, 8'h00));
        send_items(23);

        send_items(180);

        // long receiver hold-off while requests keep coming
        @(negedge i_clk) hold_cycles = 80;
        send_items(30);
        wait_drain();

        send_idle_pct = 73;
        send_items(240);
        wait_drain();

        send_idle_pct = 0;
        stall_pct     = 73;
        send_items(240);

        send_idle_pct = 25;
        stall_pct     = 25;
        send_items(240);

        wait_drain();
        repeat (TAIL) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
